>>> src/jbq_pkg.sv
// shared types, command and register codes, and reset constants for the joystick qualifier
package jbq_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LOCK_W   = 4;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned CFG_W    = SAMPLE_W;
  localparam int unsigned BTN_W    = 2;
  localparam int unsigned DIR_W    = 2;

  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST = SAMPLE_W'(3000);
  localparam logic [SAMPLE_W-1:0] LOW_THR_RST  = SAMPLE_W'(1000);
  localparam logic [SAMPLE_W-1:0] CENTER_RST   = SAMPLE_W'(2000);
  localparam logic [LOCK_W-1:0]   LOCKOUT_RST  = LOCK_W'(2);

  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_LOW  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_HIGH = 2'sb11;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_EDGE    = 3'd1,
    CMD_READ    = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_QUERY_X = 3'd4,
    CMD_QUERY_Y = 3'd5
  } cmd_e;

  typedef enum logic [IDX_W-1:0] {
    REG_HIGH_THR = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_CENTER   = 2'd2,
    REG_LOCKOUT  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high_thr;
    logic [SAMPLE_W-1:0] low_thr;
    logic [SAMPLE_W-1:0] center;
    logic [LOCK_W-1:0]   lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic                a_edge;
    logic                b_edge;
  } item_t;

  typedef struct packed {
    logic                     has_result;
    logic [BTN_W-1:0]         buttons;
    logic signed [DIR_W-1:0]  direction;
  } result_t;

endpackage

>>> src/jbq_cfg_regs.sv
// configuration register file: thresholds, center value and lockout length
module jbq_cfg_regs
  import jbq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_HIGH_THR: cfg_d.high_thr      = cfg_data_i[SAMPLE_W-1:0];
        REG_LOW_THR:  cfg_d.low_thr       = cfg_data_i[SAMPLE_W-1:0];
        REG_CENTER:   cfg_d.center        = cfg_data_i[SAMPLE_W-1:0];
        REG_LOCKOUT:  cfg_d.lockout_ticks = cfg_data_i[LOCK_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr      <= HIGH_THR_RST;
      cfg_q.low_thr       <= LOW_THR_RST;
      cfg_q.center        <= CENTER_RST;
      cfg_q.lockout_ticks <= LOCKOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/jbq_state.sv
// axis sample history, press flags and lockout counter, updated once per item
module jbq_state
  import jbq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    fire_i,
  output result_t result_o
);

  logic [SAMPLE_W-1:0] x_cur_q, x_cur_d, x_prev_q, x_prev_d;
  logic [SAMPLE_W-1:0] y_cur_q, y_cur_d, y_prev_q, y_prev_d;
  logic [BTN_W-1:0]    flags_q, flags_d;
  logic [LOCK_W-1:0]   lock_q, lock_d;

  logic [SAMPLE_W-1:0] ax_cur, ax_prev;
  logic                ax_high, ax_low;

  // pick the queried axis
  always_comb begin
    if (cmd_e'(item_i.cmd) == CMD_QUERY_X) begin
      ax_cur  = x_cur_q;
      ax_prev = x_prev_q;
    end else begin
      ax_cur  = y_cur_q;
      ax_prev = y_prev_q;
    end
    ax_high = (ax_cur > cfg_i.high_thr) && (ax_prev > cfg_i.high_thr);
    ax_low  = (ax_cur < cfg_i.low_thr) && (ax_prev < cfg_i.low_thr);
  end

  always_comb begin
    x_cur_d  = x_cur_q;
    x_prev_d = x_prev_q;
    y_cur_d  = y_cur_q;
    y_prev_d = y_prev_q;
    flags_d  = flags_q;
    lock_d   = lock_q;
    result_o = '0;
    unique case (cmd_e'(item_i.cmd))
      CMD_TICK: begin
        x_prev_d = x_cur_q;
        y_prev_d = y_cur_q;
        x_cur_d  = item_i.x_sample;
        y_cur_d  = item_i.y_sample;
        if (lock_q != '0) lock_d = lock_q - LOCK_W'(1);
      end
      CMD_EDGE: begin
        if (lock_q == '0) begin
          flags_d = flags_q | {item_i.b_edge, item_i.a_edge};
          lock_d  = cfg_i.lockout_ticks;
        end
      end
      CMD_READ: begin
        result_o.has_result = 1'b1;
        result_o.buttons    = flags_q;
        flags_d             = '0;
      end
      CMD_CLEAR: begin
        flags_d = '0;
      end
      CMD_QUERY_X, CMD_QUERY_Y: begin
        result_o.has_result = 1'b1;
        // high side wins when both tests pass
        priority if (ax_high) result_o.direction = DIR_HIGH;
        else if (ax_low)      result_o.direction = DIR_LOW;
        else                  result_o.direction = DIR_NONE;
        if (ax_high || ax_low) begin
          if (cmd_e'(item_i.cmd) == CMD_QUERY_X) x_cur_d = cfg_i.center;
          else                                   y_cur_d = cfg_i.center;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cur_q  <= '0;
      x_prev_q <= '0;
      y_cur_q  <= '0;
      y_prev_q <= '0;
      flags_q  <= '0;
      lock_q   <= '0;
    end else if (fire_i) begin
      x_cur_q  <= x_cur_d;
      x_prev_q <= x_prev_d;
      y_cur_q  <= y_cur_d;
      y_prev_q <= y_prev_d;
      flags_q  <= flags_d;
      lock_q   <= lock_d;
    end
  end

endmodule

>>> src/joystick_button_qualifier.sv
// top level: input register, state update and result register of the joystick qualifier
// an accepted item is held in the input register and its result in the result register
// throughput: one item per cycle while in_stall_o is low; items with no result never
// wait on the output side, and an item with a result waits in the input register only
// while the result register is full and stalled
// reset: async active low; clears all samples, flags, lockout count and valid bits,
// and loads the registers with 3000, 1000, 2000 and 2
module joystick_button_qualifier
  import jbq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic [SAMPLE_W-1:0]     x_sample_i,
  input  logic [SAMPLE_W-1:0]     y_sample_i,
  input  logic                    a_edge_i,
  input  logic                    b_edge_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BTN_W-1:0]        buttons_o,
  output logic signed [DIR_W-1:0] direction_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t result;
  logic    fire;
  logic    slot_free;
  logic    in_accept;

  logic                    out_valid_q;
  logic [BTN_W-1:0]        buttons_q;
  logic signed [DIR_W-1:0] direction_q;

  jbq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  jbq_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .item_i  (item_q),
    .fire_i  (fire),
    .result_o(result)
  );

  // result register can take a new result when empty or being drained this cycle
  assign slot_free = !out_valid_q || !out_stall_i;
  // the held item is processed unless its result has nowhere to go
  assign fire      = item_valid_q && (!result.has_result || slot_free);
  // input register is free when empty or when its item moves on this cycle
  assign in_stall_o = item_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.cmd      <= cmd_i;
      item_q.x_sample <= x_sample_i;
      item_q.y_sample <= y_sample_i;
      item_q.a_edge   <= a_edge_i;
      item_q.b_edge   <= b_edge_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && result.has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && result.has_result) begin
      buttons_q   <= result.buttons;
      direction_q <= result.direction;
    end
  end

  assign out_valid_o = out_valid_q;
  assign buttons_o   = buttons_q;
  assign direction_o = direction_q;

endmodule
